// ===== design/bcs_pkg.sv =====
// Package for the scalar field decoder: field kinds, status codes, the
// constants of the ULEB128 format and the item and result structs used across the modules.
// No dependencies.
package bcs_pkg;

    typedef enum logic [2:0] {
        KIND_BOOL    = 3'd0,
        KIND_U8      = 3'd1,
        KIND_U16     = 3'd2,
        KIND_U32     = 3'd3,
        KIND_U64     = 3'd4,
        KIND_U128    = 3'd5,
        KIND_VARIANT = 3'd6,
        KIND_LENGTH  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_BOOL    = 3'd1,
        STAT_ULEB_OVF    = 3'd2,
        STAT_ULEB_NONCAN = 3'd3,
        STAT_LEN_LARGE   = 3'd4,
        STAT_TRUNCATED   = 3'd5
    } status_t;

    localparam logic [7:0]  ULEB_DIGIT_MASK = 8'h7F;
    localparam int          ULEB_DIGIT_BITS = 7;
    localparam int          ULEB_VALUE_BITS = 32;
    localparam logic [4:0]  ULEB_MAX_BYTES  = 5'd5;
    localparam logic [7:0]  BOOL_MAX        = 8'd1;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd65535;

    // Width of the ULEB accumulator: four full digits plus the fifth digit.
    localparam int ULEB_ACC_BITS = 5 * ULEB_DIGIT_BITS;

    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic       first;
        logic       end_of_data;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] value_low;
        logic [63:0] value_high;
        status_t     status;
        kind_t       field_kind;
    } result_t;

    // Number of bytes in a fixed-width little-endian field.
    function automatic logic [4:0] fixed_size(input kind_t k);
        logic [4:0] n;
        case (k)
            KIND_BOOL: n = 5'd1;
            KIND_U8:   n = 5'd1;
            KIND_U16:  n = 5'd2;
            KIND_U32:  n = 5'd4;
            KIND_U64:  n = 5'd8;
            KIND_U128: n = 5'd16;
            default:   n = 5'd16;
        endcase
        return n;
    endfunction

endpackage

// ===== design/bcs_channels.sv =====
// Handshake channels of the scalar field decoder: the byte input channel
// and the result output channel. No dependencies.
interface bcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] kind;
    logic       first;
    logic       end_of_data;

    modport source (output valid, data_byte, kind, first, end_of_data, input ready);
    modport sink   (input valid, data_byte, kind, first, end_of_data, output ready);
endinterface

interface bcs_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [2:0]  status;
    logic [2:0]  field_kind;

    modport source (output valid, value_low, value_high, status, field_kind, input ready);
    modport sink   (input valid, value_low, value_high, status, field_kind, output ready);
endinterface

// ===== design/bcs_in_reg.sv =====
// Input register of the scalar field decoder: holds one byte transfer until
// the field engine consumes it. Uses bcs_pkg and bcs_byte_if.
module bcs_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    bcs_byte_if.sink       byte_in,
    input  logic           advance,
    output logic           item_valid,
    output bcs_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    bcs_pkg::item_t item_reg;
    logic           take;

    assign byte_in.ready = !valid_reg || advance;
    assign take          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte   <= byte_in.data_byte;
            item_reg.kind        <= bcs_pkg::kind_t'(byte_in.kind);
            item_reg.first       <= byte_in.first;
            item_reg.end_of_data <= byte_in.end_of_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/bcs_field_engine.sv =====
// Field engine of the scalar field decoder: field state, max_length register
// and the per-byte decode step. Uses bcs_pkg.
module bcs_field_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [31:0]      cfg_write_data,
    input  logic             step,
    input  bcs_pkg::item_t   item,
    output bcs_pkg::result_t result
);

    localparam int AB = bcs_pkg::ULEB_ACC_BITS;

    logic [31:0]     max_length_reg;
    bcs_pkg::kind_t  open_kind_reg, open_kind_next;
    logic            in_field_reg, in_field_next;
    logic [4:0]      byte_count_reg, byte_count_next;
    logic [127:0]    acc_reg, acc_next;

    bcs_pkg::kind_t  cur_kind;
    logic [4:0]      cur_cnt;
    logic [127:0]    cur_acc;
    logic            active;
    logic [127:0]    acc_w;
    logic [4:0]      cnt_w;
    logic [6:0]      digit;
    logic [4:0]      shamt;
    logic [AB-1:0]   uleb_sum;
    logic [2:0]      idx;

    always_comb
    begin
        open_kind_next  = open_kind_reg;
        in_field_next   = in_field_reg;
        byte_count_next = byte_count_reg;
        acc_next        = acc_reg;
        result          = '0;
        result.status   = bcs_pkg::STAT_OK;
        result.field_kind = open_kind_reg;

        cur_kind = item.first ? item.kind : open_kind_reg;
        cur_cnt  = item.first ? 5'd0 : byte_count_reg;
        cur_acc  = item.first ? 128'd0 : acc_reg;
        active   = item.first || in_field_reg;

        // Fixed-width path: drop the byte into the lane picked by the count.
        acc_w = cur_acc;
        for (int i = 0; i < 16; i++)
        begin
            if (cur_cnt[3:0] == 4'(i))
            begin
                acc_w[i*8 +: 8] = cur_acc[i*8 +: 8] | item.data_byte;
            end
        end
        cnt_w = {1'b0, cur_cnt[3:0]} + 5'd1;

        // ULEB path: OR the 7-bit digit in at seven times the byte index.
        idx      = cur_cnt[2:0];
        digit    = item.data_byte[6:0] & bcs_pkg::ULEB_DIGIT_MASK[6:0];
        shamt    = {2'b00, idx} * 5'd7;
        uleb_sum = cur_acc[AB-1:0] | (AB'(digit) << shamt);

        if (step)
        begin
            if (item.end_of_data)
            begin
                if (in_field_reg)
                begin
                    result.valid      = 1'b1;
                    result.status     = bcs_pkg::STAT_TRUNCATED;
                    result.field_kind = open_kind_reg;
                    in_field_next     = 1'b0;
                end
            end
            else if (active)
            begin
                open_kind_next    = cur_kind;
                in_field_next     = 1'b1;
                byte_count_next   = cur_cnt;
                acc_next          = cur_acc;
                result.field_kind = cur_kind;
                case (cur_kind)
                    bcs_pkg::KIND_BOOL:
                    begin
                        result.valid = 1'b1;
                        in_field_next = 1'b0;
                        if (item.data_byte > bcs_pkg::BOOL_MAX)
                        begin
                            result.status = bcs_pkg::STAT_BAD_BOOL;
                        end
                        else
                        begin
                            result.value_low = {56'd0, item.data_byte};
                        end
                    end
                    bcs_pkg::KIND_U8, bcs_pkg::KIND_U16, bcs_pkg::KIND_U32,
                    bcs_pkg::KIND_U64, bcs_pkg::KIND_U128:
                    begin
                        acc_next        = acc_w;
                        byte_count_next = cnt_w;
                        if (cnt_w >= bcs_pkg::fixed_size(cur_kind))
                        begin
                            result.valid      = 1'b1;
                            result.value_low  = acc_w[63:0];
                            result.value_high = acc_w[127:64];
                            in_field_next     = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (cur_cnt >= bcs_pkg::ULEB_MAX_BYTES)
                        begin
                            result.valid  = 1'b1;
                            result.status = bcs_pkg::STAT_ULEB_OVF;
                            in_field_next = 1'b0;
                        end
                        else
                        begin
                            acc_next = {{(128 - AB){1'b0}}, uleb_sum};
                            if (uleb_sum[AB-1:bcs_pkg::ULEB_VALUE_BITS] != '0)
                            begin
                                result.valid  = 1'b1;
                                result.status = bcs_pkg::STAT_ULEB_OVF;
                                in_field_next = 1'b0;
                            end
                            else if (!item.data_byte[7])
                            begin
                                result.valid  = 1'b1;
                                in_field_next = 1'b0;
                                if (cur_cnt != 5'd0 && digit == 7'd0)
                                begin
                                    result.status = bcs_pkg::STAT_ULEB_NONCAN;
                                end
                                else if (cur_kind == bcs_pkg::KIND_LENGTH &&
                                         uleb_sum[31:0] > max_length_reg)
                                begin
                                    result.status = bcs_pkg::STAT_LEN_LARGE;
                                end
                                else
                                begin
                                    result.value_low = {32'd0, uleb_sum[31:0]};
                                end
                            end
                            else
                            begin
                                byte_count_next = cur_cnt + 5'd1;
                                if (cur_cnt + 5'd1 >= bcs_pkg::ULEB_MAX_BYTES)
                                begin
                                    result.valid  = 1'b1;
                                    result.status = bcs_pkg::STAT_ULEB_OVF;
                                    in_field_next = 1'b0;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= bcs_pkg::MAX_LENGTH_RESET;
            open_kind_reg  <= bcs_pkg::KIND_BOOL;
            in_field_reg   <= 1'b0;
            byte_count_reg <= 5'd0;
            acc_reg        <= 128'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_length_reg <= cfg_write_data;
            end
            open_kind_reg  <= open_kind_next;
            in_field_reg   <= in_field_next;
            byte_count_reg <= byte_count_next;
            acc_reg        <= acc_next;
        end
    end

`ifndef SYNTHESIS
    // Every result closes the field it reports.
    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid |=> !in_field_reg)
        else $error("field still open after its result");

    // Error results never carry a value.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid && result.status != bcs_pkg::STAT_OK |->
        result.value_low == 64'd0 && result.value_high == 64'd0)
        else $error("error result with nonzero value");

    // An open ULEB field never holds five or more bytes.
    a_uleb_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg && (open_kind_reg == bcs_pkg::KIND_VARIANT ||
        open_kind_reg == bcs_pkg::KIND_LENGTH) |->
        byte_count_reg < bcs_pkg::ULEB_MAX_BYTES)
        else $error("ULEB byte count past limit in open field");

    // An open fixed-width field never holds its full byte count.
    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg && open_kind_reg != bcs_pkg::KIND_VARIANT &&
        open_kind_reg != bcs_pkg::KIND_LENGTH |->
        byte_count_reg < bcs_pkg::fixed_size(open_kind_reg))
        else $error("fixed field open with all its bytes");
`endif

endmodule

// ===== design/bcs_out_reg.sv =====
// Result register of the scalar field decoder: holds one result until the
// downstream side takes it. Uses bcs_pkg and bcs_result_if.
module bcs_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bcs_pkg::result_t result_in,
    bcs_result_if.source     result_out,
    output logic             out_free
);

    logic             valid_reg;
    logic             valid_next;
    bcs_pkg::result_t data_reg;

    assign out_free = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = result_in.valid;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result_in.valid)
        begin
            data_reg <= result_in;
        end
    end

    assign result_out.valid      = valid_reg;
    assign result_out.value_low  = data_reg.value_low;
    assign result_out.value_high = data_reg.value_high;
    assign result_out.status     = data_reg.status;
    assign result_out.field_kind = data_reg.field_kind;

`ifndef SYNTHESIS
    // A loaded result is presented in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && result_in.valid |=> result_out.valid)
        else $error("loaded result not presented");
`endif

endmodule

// ===== design/bcs_scalar_field_decoder.sv =====
// Top level of the scalar field decoder for serialized bool, fixed-width
// little-endian and ULEB128 fields. Uses bcs_pkg, bcs_channels, bcs_in_reg,
// bcs_field_engine and bcs_out_reg.
//
//   channel     direction  payload
//   byte_in     sink       data_byte[7:0], kind[2:0], first, end_of_data
//   result_out  source     value_low[63:0], value_high[63:0], status[2:0],
//                          field_kind[2:0]
//   cfg         write      cfg_write_en, cfg_write_data[31:0] (max_length)
//
// One byte transfer is taken per cycle while byte_in is ready. A result is
// presented once the byte transfer that closes its field has passed the input
// register and then the result register. Reset clears the field state and
// loads max_length with 65535. While result_out is stalled the pending result
// and one byte wait in their registers, and byte_in drops ready only when both
// are occupied.
module bcs_scalar_field_decoder (
    input  logic         clk,
    input  logic         rst_n,
    bcs_byte_if.sink     byte_in,
    bcs_result_if.source result_out,
    input  logic         cfg_write_en,
    input  logic [31:0]  cfg_write_data
);

    logic             item_valid;
    bcs_pkg::item_t   item;
    bcs_pkg::result_t result;
    logic             out_free;
    logic             step;

    // A byte is decoded when it sits in the input register and the result
    // register can take whatever that byte produces.
    assign step = item_valid && out_free;

    bcs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    bcs_field_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (step),
        .item           (item),
        .result         (result)
    );

    bcs_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result),
        .result_out (result_out),
        .out_free   (out_free)
    );

endmodule

// ===== tb/sv/tb_bcs_scalar_field_decoder.sv =====
// Self-checking testbench for the scalar field decoder: drives byte transfers, predicts
// every field result in a behavioral model and compares each result transfer against it.
// Depends on bcs_pkg, the channel interfaces in bcs_channels and the decoder top level.
`timescale 1ns / 100ps

module tb_bcs_scalar_field_decoder;

    // A run is stuck when this many cycles pass without any transfer on
    // either channel. The longest legal quiet stretch is the deliberate
    // receiver hold-off below, which is far shorter.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 5;

    // One decoded field as the decoder should report it.
    typedef struct packed {
        logic [63:0]      value_low;
        logic [63:0]      value_high;
        bcs_pkg::status_t status;
        bcs_pkg::kind_t   field_kind;
    } field_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [31:0] cfg_write_data;

    bcs_byte_if   byte_ch ();
    bcs_result_if result_ch ();

    bcs_scalar_field_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_in        (byte_ch),
        .result_out     (result_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Bytes waiting to be offered, and field results waiting to come out.
    bcs_pkg::item_t byte_q[$];
    field_result_t  field_q[$];

    // Shadow of the decoder's field state and its max_length register.
    bcs_pkg::kind_t cur_kind;
    logic           field_open;
    logic [4:0]     bytes_seen;
    logic [63:0]    acc_lo;
    logic [63:0]    acc_hi;
    logic [31:0]    max_len;

    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic long_hold;
    int   hold_count;
    logic took_byte;
    int   quiet_cycles;

    // Byte count of each fixed-width kind; the ULEB kinds have no fixed size.
    int fixed_bytes[8] = '{1, 1, 2, 4, 8, 16, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Field model
    // ------------------------------------------------------------------

    // Closes the open field and queues the result that it produces.
    task automatic close_field(input logic [63:0] lo, input logic [63:0] hi,
                               input bcs_pkg::status_t st, input bcs_pkg::kind_t k);
        field_result_t res;
        res.value_low  = lo;
        res.value_high = hi;
        res.status     = st;
        res.field_kind = k;
        field_q.push_back(res);
        field_open = 1'b0;
    endtask

    // Advances the field model by one accepted byte transfer.
    task automatic decode_byte(input bcs_pkg::item_t it);
        logic [7:0]  b;
        logic [63:0] digit;
        int          idx;
        b     = it.data_byte;
        digit = {57'd0, b[6:0]};
        // End of data closes an open field as truncated; otherwise it is a no-op.
        if (it.end_of_data)
        begin
            if (field_open)
                close_field(64'd0, 64'd0, bcs_pkg::STAT_TRUNCATED, cur_kind);
            return;
        end
        // A start byte always opens a fresh field, silently dropping any
        // field that was still open. A continuation byte with nothing open
        // is ignored.
        if (it.first)
        begin
            cur_kind   = it.kind;
            field_open = 1'b1;
            bytes_seen = 5'd0;
            acc_lo     = 64'd0;
            acc_hi     = 64'd0;
        end
        else if (!field_open)
        begin
            return;
        end

        if (cur_kind == bcs_pkg::KIND_BOOL)
        begin
            if (b > bcs_pkg::BOOL_MAX)
                close_field(64'd0, 64'd0, bcs_pkg::STAT_BAD_BOOL, cur_kind);
            else
                close_field({56'd0, b}, 64'd0, bcs_pkg::STAT_OK, cur_kind);
        end
        else if (cur_kind <= bcs_pkg::KIND_U128)
        begin
            // Little-endian: byte n lands at bit 8n of the 128-bit value.
            idx = int'(bytes_seen[3:0]);
            if (idx < 8)
                acc_lo = acc_lo | ({56'd0, b} << (8 * idx));
            else
                acc_hi = acc_hi | ({56'd0, b} << (8 * (idx - 8)));
            bytes_seen = 5'(idx + 1);
            if (bytes_seen >= fixed_bytes[cur_kind])
                close_field(acc_lo, acc_hi, bcs_pkg::STAT_OK, cur_kind);
        end
        else
        begin
            // ULEB128: seven value bits per byte, bit 7 means more follow.
            // The overflow test comes before the final-digit test.
            idx = int'(bytes_seen);
            if (idx >= bcs_pkg::ULEB_MAX_BYTES)
            begin
                close_field(64'd0, 64'd0, bcs_pkg::STAT_ULEB_OVF, cur_kind);
                return;
            end
            acc_lo = acc_lo | (digit << (bcs_pkg::ULEB_DIGIT_BITS * idx));
            if (acc_lo[63:bcs_pkg::ULEB_VALUE_BITS] != '0)
                close_field(64'd0, 64'd0, bcs_pkg::STAT_ULEB_OVF, cur_kind);
            else if (!b[7])
            begin
                if (idx > 0 && digit == 64'd0)
                    close_field(64'd0, 64'd0, bcs_pkg::STAT_ULEB_NONCAN, cur_kind);
                else if (cur_kind == bcs_pkg::KIND_LENGTH && acc_lo > {32'd0, max_len})
                    close_field(64'd0, 64'd0, bcs_pkg::STAT_LEN_LARGE, cur_kind);
                else
                    close_field(acc_lo, 64'd0, bcs_pkg::STAT_OK, cur_kind);
            end
            else
            begin
                bytes_seen = 5'(idx + 1);
                if (bytes_seen >= bcs_pkg::ULEB_MAX_BYTES)
                    close_field(64'd0, 64'd0, bcs_pkg::STAT_ULEB_OVF, cur_kind);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b, input bcs_pkg::kind_t k, input logic f,
                            input logic eod);
        bcs_pkg::item_t it;
        it.data_byte   = b;
        it.kind        = k;
        it.first       = f;
        it.end_of_data = eod;
        byte_q.push_back(it);
    endtask

    // Continuation bytes carry a random kind, which the decoder must ignore.
    task automatic put_next(input logic [7:0] b);
        put_byte(b, bcs_pkg::kind_t'($urandom_range(0, 7)), 1'b0, 1'b0);
    endtask

    task automatic put_end_of_data();
        put_byte(8'($urandom_range(0, 255)), bcs_pkg::kind_t'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // Queues a ULEB field. Style 0 is the canonical encoding of v, style 1
    // pads it with a zero final digit, style 2 carries more than 32 bits in
    // the fifth byte, and style 3 keeps the continuation bit on all five bytes.
    task automatic put_uleb(input bcs_pkg::kind_t k, input logic [31:0] v,
                            input int style);
        logic [7:0]  enc[$];
        logic [31:0] rest;
        int          n;
        rest = v;
        if (style >= 2)
        begin
            for (n = 0; n < 4; n++)
                enc.push_back(8'h80 | 8'($urandom_range(0, 127)));
            if (style == 2)
                enc.push_back(8'($urandom_range(16, 255)));
            else
                enc.push_back(8'h80 | 8'($urandom_range(0, 15)));
        end
        else
        begin
            do
            begin
                enc.push_back({rest[31:7] != 0, rest[6:0]});
                rest = rest >> bcs_pkg::ULEB_DIGIT_BITS;
            end
            while (rest != 0);
            if (style == 1 && enc.size() < 5)
            begin
                enc[enc.size() - 1] = enc[enc.size() - 1] | 8'h80;
                enc.push_back(8'h00);
            end
        end
        put_byte(enc[0], k, 1'b1, 1'b0);
        for (n = 1; n < enc.size(); n++)
            put_next(enc[n]);
    endtask

    // Queues one complete, mostly well-formed field of a random kind.
    task automatic put_field();
        bcs_pkg::kind_t k;
        logic [31:0]    v;
        int             n;
        int             pick;
        k = bcs_pkg::kind_t'($urandom_range(0, 7));
        if (k == bcs_pkg::KIND_BOOL)
        begin
            if ($urandom_range(0, 99) < 85)
                put_byte(8'($urandom_range(0, 1)), k, 1'b1, 1'b0);
            else
                put_byte(8'($urandom_range(0, 255)), k, 1'b1, 1'b0);
        end
        else if (k <= bcs_pkg::KIND_U128)
        begin
            put_byte(8'($urandom_range(0, 255)), k, 1'b1, 1'b0);
            for (n = 1; n < fixed_bytes[k]; n++)
                put_next(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Values of every encoded length, with lengths clustered around
            // the limit so that both sides of the comparison are exercised.
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = 32'd0;
            else if (k == bcs_pkg::KIND_LENGTH && pick < 4)
                v = max_len + 32'($urandom_range(0, 4)) - 32'd2;
            else
                v = $urandom() >> $urandom_range(0, 31);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                put_uleb(k, v, 0);
            else if (pick < 85)
                put_uleb(k, v, 1);
            else if (pick < 93)
                put_uleb(k, v, 2);
            else
                put_uleb(k, v, 3);
        end
    endtask

    // Fills the pending queue with one phase worth of random traffic.
    task automatic build_random_phase(input int count);
        int start;
        int len;
        int cut;
        int pick;
        start = byte_q.size();
        while (byte_q.size() - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                put_field();
            else if (pick < 88)
            begin
                // Cut a field short, then either end the data or let the
                // next start byte drop it.
                len = byte_q.size();
                put_field();
                len = byte_q.size() - len;
                if (len > 1)
                begin
                    cut = $urandom_range(1, len - 1);
                    repeat (cut) void'(byte_q.pop_back());
                end
                if ($urandom_range(0, 1))
                    put_end_of_data();
            end
            else if (pick < 94)
                put_next(8'($urandom_range(0, 255)));
            else
                put_end_of_data();
        end
    endtask

    // Short directed opening: every kind, the field extremes and each error.
    task automatic build_directed();
        put_byte(8'h00, bcs_pkg::KIND_BOOL, 1'b1, 1'b0);
        put_byte(8'h01, bcs_pkg::KIND_BOOL, 1'b1, 1'b0);
        put_byte(8'hFF, bcs_pkg::KIND_BOOL, 1'b1, 1'b0);        // bool above one
        put_byte(8'hFF, bcs_pkg::KIND_U8, 1'b1, 1'b0);
        put_byte(8'h00, bcs_pkg::KIND_U16, 1'b1, 1'b0);
        put_next(8'hFF);
        put_byte(8'hFF, bcs_pkg::KIND_U32, 1'b1, 1'b0);
        put_next(8'hFF);
        put_next(8'hFF);
        put_next(8'hFF);
        put_byte(8'hAB, bcs_pkg::KIND_U64, 1'b1, 1'b0);         // dropped by the next start
        put_byte(8'h00, bcs_pkg::KIND_VARIANT, 1'b1, 1'b0);
        put_byte(8'h80, bcs_pkg::KIND_LENGTH, 1'b1, 1'b0);      // zero final digit
        put_next(8'h00);
        put_byte(8'hFF, bcs_pkg::KIND_VARIANT, 1'b1, 1'b0);     // more than 32 bits
        put_next(8'hFF);
        put_next(8'hFF);
        put_next(8'hFF);
        put_next(8'h1F);
        put_byte(8'h80, bcs_pkg::KIND_LENGTH, 1'b1, 1'b0);      // 65536, over the reset limit
        put_next(8'h80);
        put_next(8'h04);
        put_byte(8'h11, bcs_pkg::KIND_U128, 1'b1, 1'b0);        // truncated by end of data
        put_end_of_data();
        put_end_of_data();                                      // nothing open: no result
        put_next(8'h5A);                                        // nothing open: ignored
    endtask

    // Waits until every queued byte went in and every result came out, then
    // gives bytes that close no field time to clear the pipeline.
    task automatic wait_drained();
        while (byte_q.size() != 0 || field_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [31:0] v);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        max_len = v;
    endtask

    // ------------------------------------------------------------------
    // Byte sender: offers the head of the pending queue. Once valid is up it
    // stays up with the same byte until the transfer happens.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        took_byte <= rst_n && byte_ch.valid && byte_ch.ready;
        if (rst_n && byte_ch.valid && byte_ch.ready)
            decode_byte(byte_q.pop_front());
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (byte_ch.valid && !took_byte)
            byte_ch.valid <= 1'b1;
        else if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            byte_ch.valid       <= 1'b1;
            byte_ch.data_byte   <= byte_q[0].data_byte;
            byte_ch.kind        <= byte_q[0].kind;
            byte_ch.first       <= byte_q[0].first;
            byte_ch.end_of_data <= byte_q[0].end_of_data;
        end
        else
            byte_ch.valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result receiver. The one long hold-off is counted here; it lets the
    // decoder fill up so that it has to stall its byte input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (long_hold && hold_count < HOLD_OFF_CYCLES)
        begin
            result_ch.ready <= 1'b0;
            hold_count      <= hold_count + 1;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every result transfer is checked against the oldest predicted result.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (field_q.size() == 0)
            begin
                $error("result with none expected: status %0d kind %0d",
                       result_ch.status, result_ch.field_kind);
                fail_count++;
            end
            else
            begin
                if (result_ch.value_low !== field_q[0].value_low)
                begin
                    $error("value_low: expected %h, got %h",
                           field_q[0].value_low, result_ch.value_low);
                    fail_count++;
                end
                if (result_ch.value_high !== field_q[0].value_high)
                begin
                    $error("value_high: expected %h, got %h",
                           field_q[0].value_high, result_ch.value_high);
                    fail_count++;
                end
                if (result_ch.status !== field_q[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           field_q[0].status, result_ch.status);
                    fail_count++;
                end
                if (result_ch.field_kind !== field_q[0].field_kind)
                begin
                    $error("field_kind: expected %0d, got %0d",
                           field_q[0].field_kind, result_ch.field_kind);
                    fail_count++;
                end
                void'(field_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: reset, then five phases that each pair a max_length
    // setting with an idling pattern. The first phase runs at the reset
    // value with the long receiver hold-off; later phases reach both
    // extremes of the register.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        cfg_write_en         = 1'b0;
        cfg_write_data       = 32'd0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'd0;
        byte_ch.kind         = 3'd0;
        byte_ch.first        = 1'b0;
        byte_ch.end_of_data  = 1'b0;
        result_ch.ready      = 1'b0;
        took_byte            = 1'b0;
        quiet_cycles         = 0;
        hold_count           = 0;
        long_hold            = 1'b0;
        fail_count           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        cur_kind             = bcs_pkg::KIND_BOOL;
        field_open           = 1'b0;
        bytes_seen           = 5'd0;
        acc_lo               = 64'd0;
        acc_hi               = 64'd0;
        max_len              = bcs_pkg::MAX_LENGTH_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    long_hold      = 1'b1;
                    build_directed();
                end
                1:
                begin
                    write_max_length(32'd0);
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    write_max_length(32'hFFFF_FFFF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                3:
                begin
                    write_max_length($urandom_range(1, 400));
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
                default:
                begin
                    write_max_length($urandom());
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            build_random_phase(ITEMS_PER_PHASE);
            wait_drained();
        end

        if (fail_count == 0 && field_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
